[hdl/drfpa_pkg.sv]
// Package for the dual-range frame parser and averager: shared widths, codes and
// control/response structs for the divider and CRC units. No dependencies.
`timescale 1ns / 1ps

package drfpa_pkg;

  localparam int unsigned DIST_W   = 16;  // distances, bounds, held distance
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUM_W    = 24;  // batch sums
  localparam int unsigned CNT_W    = 8;   // batch frame counts
  localparam int unsigned DIV_W    = 24;  // divider dividend and quotient
  localparam int unsigned DVS_W    = 8;   // divider divisor
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h54;  // 'T'

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOF_MIN   = 3'd0,
    REG_TOF_MAX   = 3'd1,
    REG_SOUND_MIN = 3'd2,
    REG_SOUND_MAX = 3'd3,
    REG_DIVISOR   = 3'd4,
    REG_CRC_POLY  = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_TOF   = 2'd1,
    SRC_SOUND = 2'd2
  } source_t;

  typedef enum logic [1:0] {
    STATUS_GOOD = 2'd0,
    STATUS_HIGH = 2'd1,
    STATUS_LOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] poly;
  } crc_ctl_t;

endpackage

[hdl/drfpa_if.sv]
// Handshake channels of the frame parser: the input item channel and the result channel.
// Depends on drfpa_pkg for field widths.
`timescale 1ns / 1ps

interface drfpa_item_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [drfpa_pkg::BYTE_W-1:0]      rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface drfpa_result_if;
  logic                              valid;
  logic                              ready;
  logic                              new_reading;
  logic [1:0]                        reading_source;
  logic [drfpa_pkg::DIST_W-1:0]      reading_cm;
  logic [1:0]                        range_status;

  modport source (output valid, output new_reading, output reading_source,
                  output reading_cm, output range_status, input ready);
  modport sink   (input valid, input new_reading, input reading_source,
                  input reading_cm, input range_status, output ready);
endinterface

[hdl/drfpa_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on drfpa_pkg for widths and request/response structs.
`timescale 1ns / 1ps

module drfpa_div (
  input  logic                clk,
  input  logic                rst,
  input  drfpa_pkg::div_req_t req,
  output drfpa_pkg::div_rsp_t rsp
);

  localparam int unsigned STEP_W = $clog2(drfpa_pkg::DIV_W);

  logic                          busy;
  logic                          done;
  logic [STEP_W-1:0]             step;
  logic [drfpa_pkg::DVS_W-1:0]   rem;
  logic [drfpa_pkg::DVS_W-1:0]   dvs;
  logic [drfpa_pkg::DIV_W-1:0]   quo;
  logic [drfpa_pkg::DVS_W:0]     trial;
  logic [drfpa_pkg::DVS_W+1:0]   diff;

  always_comb begin
    trial = {rem, quo[drfpa_pkg::DIV_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        // zero divisor divides as one
        dvs  <= (req.divisor == '0) ? drfpa_pkg::DVS_W'(1) : req.divisor;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[drfpa_pkg::DVS_W+1]) begin
          rem <= diff[drfpa_pkg::DVS_W-1:0];
          quo <= {quo[drfpa_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= trial[drfpa_pkg::DVS_W-1:0];
          quo <= {quo[drfpa_pkg::DIV_W-2:0], 1'b0};
        end
        if (step == STEP_W'(drfpa_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[hdl/drfpa_crc.sv]
// CRC-8 accumulator, MSB first, zero init: folds one stored byte per cycle while stepped.
// Depends on drfpa_pkg for the control struct.
`timescale 1ns / 1ps

module drfpa_crc (
  input  logic                          clk,
  input  drfpa_pkg::crc_ctl_t           ctl,
  output logic [drfpa_pkg::BYTE_W-1:0]  crc
);

  logic [drfpa_pkg::BYTE_W-1:0] crc_next;

  always_comb begin
    crc_next = crc ^ ctl.data;
    for (int b = 0; b < drfpa_pkg::BYTE_W; b++) begin
      if (crc_next[drfpa_pkg::BYTE_W-1]) begin
        crc_next = {crc_next[drfpa_pkg::BYTE_W-2:0], 1'b0} ^ ctl.poly;
      end else begin
        crc_next = {crc_next[drfpa_pkg::BYTE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      crc <= '0;
    end else if (ctl.step) begin
      crc <= crc_next;
    end
  end

endmodule

[hdl/dual_range_frame_parser_averager.sv]
// Dual-range frame parser and averager. Takes sensor UART bytes (cmd 0) and end-of-batch
// commands (cmd 1) on the item channel. A 'T' byte restarts a frame at any point; after
// FRAME_LEN bytes the frame's CRC-8 (programmable polynomial, MSB first, zero init) is
// checked over the first FRAME_LEN-1 bytes against the last. Good frames give a
// time-of-flight and a sound distance (bytes 1-2 and 4-5, big-endian, divided by
// raw_to_cm_divisor); the ToF one is summed per batch if in its window, else the sound
// one if in its window, counts capped at MAX_FRAMES. An end-of-batch command yields one
// result beat: the held distance (the batch average, ToF first, else sound) and its
// range status. The byte that completes a frame starts the check: the CRC unit folds
// one stored byte per cycle, then two scale divisions run back to back on the single
// shared divider at one quotient bit per cycle; a frame whose checksum fails is dropped
// after the CRC check. An end-of-batch command runs one pass of the same divider (none
// for an empty batch), then waits for any previous result beat to be taken. The item
// channel is ready only while the sequencer is idle; a finished result sits in the
// output register and does not hold off the next item.
`timescale 1ns / 1ps

module dual_range_frame_parser_averager #(
  parameter int unsigned FRAME_LEN  = 10,
  parameter int unsigned MAX_FRAMES = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  drfpa_item_if.sink                          item,
  drfpa_result_if.source                      result,
  input  logic                                cfg_we,
  input  logic [drfpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drfpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam int unsigned BI_W  = $clog2(FRAME_LEN + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_TOF_GO,
    ST_TOF_WAIT,
    ST_SND_GO,
    ST_SND_WAIT,
    ST_ACC,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_EMIT
  } state_t;

  // Configuration registers
  logic [drfpa_pkg::DIST_W-1:0] tof_min_cm;
  logic [drfpa_pkg::DIST_W-1:0] tof_max_cm;
  logic [drfpa_pkg::DIST_W-1:0] sound_min_cm;
  logic [drfpa_pkg::DIST_W-1:0] sound_max_cm;
  logic [drfpa_pkg::DVS_W-1:0]  raw_to_cm_divisor;
  logic [drfpa_pkg::BYTE_W-1:0] crc_polynomial;

  // Frame parsing state
  logic [drfpa_pkg::BYTE_W-1:0] frame_store [FRAME_LEN];
  logic [BI_W-1:0]              byte_index;
  logic                         in_frame;
  logic [IDX_W-1:0]             check_idx;

  // Batch accumulators and held reading
  logic [drfpa_pkg::SUM_W-1:0]  tof_sum;
  logic [drfpa_pkg::CNT_W-1:0]  tof_frames;
  logic [drfpa_pkg::SUM_W-1:0]  sound_sum;
  logic [drfpa_pkg::CNT_W-1:0]  sound_frames;
  logic [drfpa_pkg::DIST_W-1:0] held_distance;
  logic [drfpa_pkg::DIST_W-1:0] tof_cm;
  logic [drfpa_pkg::DIST_W-1:0] sound_cm;
  drfpa_pkg::source_t           batch_src;

  // Output register
  logic                         out_valid;
  logic                         out_new;
  drfpa_pkg::source_t           out_src;
  logic [drfpa_pkg::DIST_W-1:0] out_dist;
  drfpa_pkg::status_t           out_status;

  state_t                       state;

  // Shared units
  drfpa_pkg::div_req_t          div_req;
  drfpa_pkg::div_rsp_t          div_rsp;
  drfpa_pkg::crc_ctl_t          crc_ctl;
  logic [drfpa_pkg::BYTE_W-1:0] crc;

  // Combinational helpers
  logic                         item_fire;
  logic                         start_hit;
  logic                         frame_on;
  logic [BI_W-1:0]              idx_base;
  logic [BI_W-1:0]              idx_inc;
  logic                         frame_full;
  logic                         tof_ok;
  logic                         snd_ok;
  logic                         out_load;
  drfpa_pkg::status_t           status_now;

  assign item.ready = (state == ST_IDLE);
  assign item_fire  = item.valid && item.ready;

  // A start byte restarts the frame wherever the parser stands
  always_comb begin
    start_hit  = (item.rx_byte == drfpa_pkg::START_BYTE);
    frame_on   = in_frame || start_hit;
    idx_base   = start_hit ? '0 : byte_index;
    idx_inc    = idx_base + BI_W'(1);
    frame_full = frame_on && (idx_inc == BI_W'(FRAME_LEN));
  end

  // Scale divisions and the batch average all go through the one divider
  always_comb begin
    div_req.start    = (state == ST_TOF_GO) || (state == ST_SND_GO) || (state == ST_AVG_GO);
    div_req.divisor  = raw_to_cm_divisor;
    div_req.dividend = {{(drfpa_pkg::DIV_W - 2 * drfpa_pkg::BYTE_W){1'b0}},
                        frame_store[1], frame_store[2]};
    case (state)
      ST_SND_GO: begin
        div_req.dividend = {{(drfpa_pkg::DIV_W - 2 * drfpa_pkg::BYTE_W){1'b0}},
                            frame_store[4], frame_store[5]};
      end
      ST_AVG_GO: begin
        if (batch_src == drfpa_pkg::SRC_TOF) begin
          div_req.dividend = tof_sum;
          div_req.divisor  = tof_frames;
        end else begin
          div_req.dividend = sound_sum;
          div_req.divisor  = sound_frames;
        end
      end
      default: begin
      end
    endcase
  end

  // Clear the CRC as the last frame byte lands, then fold one byte per cycle
  always_comb begin
    crc_ctl.clear = (state == ST_IDLE) && item_fire && !item.cmd && frame_full;
    crc_ctl.step  = (state == ST_CRC);
    crc_ctl.data  = frame_store[check_idx];
    crc_ctl.poly  = crc_polynomial;
  end

  // Window tests: all bounds exclusive
  always_comb begin
    tof_ok = (tof_cm > tof_min_cm) && (tof_cm < tof_max_cm);
    snd_ok = (sound_cm > sound_min_cm) && (sound_cm < sound_max_cm);
  end

  // Held distance is judged as a signed 16-bit value
  always_comb begin
    if ($signed({held_distance[drfpa_pkg::DIST_W-1], held_distance}) >
        $signed({1'b0, tof_max_cm})) begin
      status_now = drfpa_pkg::STATUS_HIGH;
    end else if ($signed({held_distance[drfpa_pkg::DIST_W-1], held_distance}) <
                 $signed({1'b0, sound_min_cm})) begin
      status_now = drfpa_pkg::STATUS_LOW;
    end else begin
      status_now = drfpa_pkg::STATUS_GOOD;
    end
  end

  assign out_load = (state == ST_EMIT) && (!out_valid || result.ready);

  drfpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  drfpa_crc u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tof_min_cm        <= drfpa_pkg::DIST_W'(5);
      tof_max_cm        <= drfpa_pkg::DIST_W'(1400);
      sound_min_cm      <= drfpa_pkg::DIST_W'(20);
      sound_max_cm      <= drfpa_pkg::DIST_W'(765);
      raw_to_cm_divisor <= drfpa_pkg::DVS_W'(10);
      crc_polynomial    <= drfpa_pkg::BYTE_W'(7);
    end else if (cfg_we) begin
      case (cfg_index)
        drfpa_pkg::REG_TOF_MIN:   tof_min_cm        <= cfg_data;
        drfpa_pkg::REG_TOF_MAX:   tof_max_cm        <= cfg_data;
        drfpa_pkg::REG_SOUND_MIN: sound_min_cm      <= cfg_data;
        drfpa_pkg::REG_SOUND_MAX: sound_max_cm      <= cfg_data;
        drfpa_pkg::REG_DIVISOR:   raw_to_cm_divisor <= cfg_data[drfpa_pkg::DVS_W-1:0];
        drfpa_pkg::REG_CRC_POLY:  crc_polynomial    <= cfg_data[drfpa_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame store: written as bytes arrive, no reset
  always_ff @(posedge clk) begin
    if (item_fire && !item.cmd && frame_on) begin
      frame_store[idx_base[IDX_W-1:0]] <= item.rx_byte;
    end
  end

  // Sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_index    <= '0;
      in_frame      <= 1'b0;
      check_idx     <= '0;
      tof_sum       <= '0;
      tof_frames    <= '0;
      sound_sum     <= '0;
      sound_frames  <= '0;
      held_distance <= '0;
      batch_src     <= drfpa_pkg::SRC_NONE;
      out_valid     <= 1'b0;
      out_new       <= 1'b0;
      out_src       <= drfpa_pkg::SRC_NONE;
      out_dist      <= '0;
      out_status    <= drfpa_pkg::STATUS_GOOD;
    end else begin
      // drop the beat once taken, unless a new one loads in its place
      if (result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_fire) begin
            if (!item.cmd) begin
              if (frame_on) begin
                if (frame_full) begin
                  // frame complete: rewind the parser and check it
                  byte_index <= '0;
                  in_frame   <= 1'b0;
                  check_idx  <= '0;
                  state      <= ST_CRC;
                end else begin
                  byte_index <= idx_inc;
                  in_frame   <= 1'b1;
                end
              end
            end else if (tof_frames != '0) begin
              batch_src <= drfpa_pkg::SRC_TOF;
              state     <= ST_AVG_GO;
            end else if (sound_frames != '0) begin
              batch_src <= drfpa_pkg::SRC_SOUND;
              state     <= ST_AVG_GO;
            end else begin
              batch_src <= drfpa_pkg::SRC_NONE;
              state     <= ST_EMIT;
            end
          end
        end
        ST_CRC: begin
          check_idx <= check_idx + IDX_W'(1);
          if (check_idx == IDX_W'(FRAME_LEN - 2)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= (crc == frame_store[FRAME_LEN-1]) ? ST_TOF_GO : ST_IDLE;
        end
        ST_TOF_GO: begin
          state <= ST_TOF_WAIT;
        end
        ST_TOF_WAIT: begin
          if (div_rsp.done) begin
            tof_cm <= div_rsp.quotient[drfpa_pkg::DIST_W-1:0];
            state  <= ST_SND_GO;
          end
        end
        ST_SND_GO: begin
          state <= ST_SND_WAIT;
        end
        ST_SND_WAIT: begin
          if (div_rsp.done) begin
            sound_cm <= div_rsp.quotient[drfpa_pkg::DIST_W-1:0];
            state    <= ST_ACC;
          end
        end
        ST_ACC: begin
          // ToF wins when in window; a full count drops the sample
          if (tof_ok) begin
            if (tof_frames < drfpa_pkg::CNT_W'(MAX_FRAMES)) begin
              tof_sum    <= tof_sum + {{(drfpa_pkg::SUM_W - drfpa_pkg::DIST_W){1'b0}}, tof_cm};
              tof_frames <= tof_frames + drfpa_pkg::CNT_W'(1);
            end
          end else if (snd_ok) begin
            if (sound_frames < drfpa_pkg::CNT_W'(MAX_FRAMES)) begin
              sound_sum    <= sound_sum +
                              {{(drfpa_pkg::SUM_W - drfpa_pkg::DIST_W){1'b0}}, sound_cm};
              sound_frames <= sound_frames + drfpa_pkg::CNT_W'(1);
            end
          end
          state <= ST_IDLE;
        end
        ST_AVG_GO: begin
          state <= ST_AVG_WAIT;
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            held_distance <= div_rsp.quotient[drfpa_pkg::DIST_W-1:0];
            state         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the previous beat is taken, then load and clear the batch
          if (out_load) begin
            out_valid    <= 1'b1;
            out_new      <= (batch_src != drfpa_pkg::SRC_NONE);
            out_src      <= batch_src;
            out_dist     <= held_distance;
            out_status   <= status_now;
            tof_sum      <= '0;
            tof_frames   <= '0;
            sound_sum    <= '0;
            sound_frames <= '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.new_reading    = out_new;
  assign result.reading_source = out_src;
  assign result.reading_cm     = out_dist;
  assign result.range_status   = out_status;

`ifndef NO_ASSERTIONS
  a_counts_capped: assert property (@(posedge clk) disable iff (rst)
    (tof_frames <= drfpa_pkg::CNT_W'(MAX_FRAMES)) &&
    (sound_frames <= drfpa_pkg::CNT_W'(MAX_FRAMES)))
    else $error("batch frame count above cap");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_index < BI_W'(FRAME_LEN))
    else $error("byte index ran past frame length");

  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (tof_frames == '0) && (sound_frames == '0) &&
                 (tof_sum == '0) && (sound_sum == '0))
    else $error("batch not cleared after result load");

  a_new_matches_src: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.new_reading ==
                      (result.reading_source != drfpa_pkg::SRC_NONE)))
    else $error("new_reading disagrees with reading_source");
`endif

endmodule
